// ===== src/uerc_pkg.sv =====
// Shared types, constants and checksum helpers for the UDP echo reply core.
// No dependencies; compiled first.
`default_nettype none

package uerc_pkg;

  localparam logic [5:0]  MIN_HDR_LEN = 6'd20;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;
  localparam logic [7:0]  REPLY_TTL   = 8'd64;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] BYTE_COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_REPLY       = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_BAD_UDP_LEN = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_NOT_OURS    = 3'd4,
    ST_EMPTY       = 3'd5
  } status_t;

  // state of one finished packet, taken on its last item
  typedef struct packed {
    logic [5:0]  hl;
    logic [15:0] plen;
    logic [15:0] byte_count;
    logic [21:0] ip_sum;
    logic [31:0] udp_sum;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] udp_length;
  } snap_t;

  // checked packet with unfolded checksum sums
  typedef struct packed {
    status_t     status;
    logic [15:0] ip_len;
    logic [33:0] ip_raw;
    logic [33:0] udp_raw;
    logic [31:0] local_ip;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] data_len;
  } sum_t;

  function automatic logic [16:0] words32(input logic [31:0] v);
    return {1'b0, v[31:16]} + {1'b0, v[15:0]};
  endfunction

  // end-around carry fold of a 34-bit sum to 16 bits
  function automatic logic [15:0] fold16(input logic [33:0] s);
    logic [18:0] s1;
    logic [16:0] s2;
    s1 = {3'b000, s[15:0]} + {1'b0, s[33:16]};
    s2 = {1'b0, s1[15:0]} + {14'b0, s1[18:16]};
    return s2[15:0] + {15'b0, s2[16]};
  endfunction

endpackage

`default_nettype wire

// ===== src/uerc_if.sv =====
// Valid/ready channel interfaces for packet bytes in and reply results out.
// Depends on nothing.
`default_nettype none

interface uerc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [5:0]  header_len;
  logic [15:0] packet_len;
  logic        last;

  modport source (output valid, data_byte, header_len, packet_len, last, input ready);
  modport sink   (input valid, data_byte, header_len, packet_len, last, output ready);
endinterface

interface uerc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] reply_ip_len;
  logic [15:0] reply_ip_checksum;
  logic [15:0] reply_udp_checksum;
  logic [31:0] reply_src_ip;
  logic [31:0] reply_dst_ip;
  logic [15:0] reply_src_port;
  logic [15:0] reply_dst_port;
  logic [15:0] reply_data_len;

  modport source (output valid, status, reply_ip_len, reply_ip_checksum,
                  reply_udp_checksum, reply_src_ip, reply_dst_ip, reply_src_port,
                  reply_dst_port, reply_data_len, input ready);
  modport sink   (input valid, status, reply_ip_len, reply_ip_checksum,
                  reply_udp_checksum, reply_src_ip, reply_dst_ip, reply_src_port,
                  reply_dst_port, reply_data_len, output ready);
endinterface

`default_nettype wire

// ===== src/uerc_accum.sv =====
// Per-byte accumulator: captures header fields, builds running word sums and
// hands a snapshot of each finished packet on. Depends on uerc_pkg, uerc_if.
`default_nettype none

module uerc_accum (
  input  wire logic           clk,
  input  wire logic           rst,
  uerc_in_if.sink             pkt,
  output uerc_pkg::snap_t     snap,
  output logic                snap_valid,
  input  wire logic           snap_ready
);

  logic [15:0] byte_count, byte_count_next;
  logic [21:0] ip_sum, ip_sum_next;
  logic [31:0] udp_sum, udp_sum_next;
  logic [31:0] src_ip, src_ip_next;
  logic [31:0] dst_ip, dst_ip_next;
  logic [15:0] src_port, src_port_next;
  logic [15:0] dst_port, dst_port_next;
  logic [15:0] udp_length, udp_length_next;

  logic        accept;
  logic        stage_ready;
  logic [5:0]  hl;
  logic [15:0] pos;
  logic [15:0] u;
  logic [15:0] w;
  logic [15:0] uw;

  assign stage_ready = !snap_valid || snap_ready;
  assign pkt.ready   = stage_ready;
  assign accept      = pkt.valid && stage_ready;

  assign hl  = (pkt.header_len < uerc_pkg::MIN_HDR_LEN) ? uerc_pkg::MIN_HDR_LEN
                                                         : pkt.header_len;
  assign pos = byte_count;
  assign u   = pos - {10'b0, hl};
  assign w   = pos[0] ? {8'h00, pkt.data_byte} : {pkt.data_byte, 8'h00};
  assign uw  = u[0]   ? {8'h00, pkt.data_byte} : {pkt.data_byte, 8'h00};

  always_comb begin
    byte_count_next = byte_count;
    ip_sum_next     = ip_sum;
    udp_sum_next    = udp_sum;
    src_ip_next     = src_ip;
    dst_ip_next     = dst_ip;
    src_port_next   = src_port;
    dst_port_next   = dst_port;
    udp_length_next = udp_length;
    if (byte_count != uerc_pkg::BYTE_COUNT_MAX) begin
      byte_count_next = byte_count + 16'd1;
      if (pos < {10'b0, hl}) begin
        case (pos) inside
          [16'd12:16'd15]: src_ip_next = {src_ip[23:0], pkt.data_byte};
          [16'd16:16'd19]: dst_ip_next = {dst_ip[23:0], pkt.data_byte};
          16'd2, 16'd3, 16'd8, 16'd10, 16'd11: begin
          end
          default: ip_sum_next = ip_sum + {6'b0, w};
        endcase
      end else if (u < 16'd2) begin
        src_port_next = {src_port[7:0], pkt.data_byte};
        udp_sum_next  = udp_sum + {16'b0, uw};
      end else if (u < 16'd4) begin
        dst_port_next = {dst_port[7:0], pkt.data_byte};
        udp_sum_next  = udp_sum + {16'b0, uw};
      end else if (u < 16'd6) begin
        udp_length_next = {udp_length[7:0], pkt.data_byte};
      end else if (u >= uerc_pkg::UDP_HDR_LEN && u < udp_length) begin
        udp_sum_next = udp_sum + {16'b0, uw};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      ip_sum     <= '0;
      udp_sum    <= '0;
      src_ip     <= '0;
      dst_ip     <= '0;
      src_port   <= '0;
      dst_port   <= '0;
      udp_length <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (accept) begin
        snap_valid <= pkt.last;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
      if (accept) begin
        if (pkt.last) begin
          byte_count <= '0;
          ip_sum     <= '0;
          udp_sum    <= '0;
          src_ip     <= '0;
          dst_ip     <= '0;
          src_port   <= '0;
          dst_port   <= '0;
          udp_length <= '0;
        end else begin
          byte_count <= byte_count_next;
          ip_sum     <= ip_sum_next;
          udp_sum    <= udp_sum_next;
          src_ip     <= src_ip_next;
          dst_ip     <= dst_ip_next;
          src_port   <= src_port_next;
          dst_port   <= dst_port_next;
          udp_length <= udp_length_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pkt.last) begin
      snap.hl         <= hl;
      snap.plen       <= pkt.packet_len;
      snap.byte_count <= byte_count_next;
      snap.ip_sum     <= ip_sum_next;
      snap.udp_sum    <= udp_sum_next;
      snap.src_ip     <= src_ip_next;
      snap.dst_ip     <= dst_ip_next;
      snap.src_port   <= src_port_next;
      snap.dst_port   <= dst_port_next;
      snap.udp_length <= udp_length_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && pkt.last) |=> (byte_count == '0 && ip_sum == '0 && udp_sum == '0))
    else $error("running state not cleared after last item");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !pkt.last && byte_count != uerc_pkg::BYTE_COUNT_MAX)
      |=> byte_count == $past(byte_count) + 16'd1)
    else $error("byte count did not advance");

  a_snap_hold: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && !snap_ready) |=> (snap_valid && $stable(snap)))
    else $error("stalled snapshot changed");

endmodule

`default_nettype wire

// ===== src/uerc_sum.sv =====
// Check stage: length, address and payload checks plus unfolded checksum sums.
// Depends on uerc_pkg.
`default_nettype none

module uerc_sum (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire uerc_pkg::snap_t snap,
  input  wire logic            snap_valid,
  output logic                 snap_ready,
  input  wire logic [31:0]     local_ip,
  output uerc_pkg::sum_t       sum,
  output logic                 sum_valid,
  input  wire logic            sum_ready
);

  logic [16:0]       need;
  logic [16:0]       min_len;
  uerc_pkg::status_t status;
  logic [16:0]       local_words;
  logic [16:0]       src_words;

  assign snap_ready  = !sum_valid || sum_ready;
  assign need        = {11'b0, snap.hl} + {1'b0, snap.udp_length};
  assign min_len     = {11'b0, snap.hl} + {1'b0, uerc_pkg::UDP_HDR_LEN};
  assign local_words = uerc_pkg::words32(local_ip);
  assign src_words   = uerc_pkg::words32(snap.src_ip);

  always_comb begin
    if ({1'b0, snap.plen} < min_len) begin
      status = uerc_pkg::ST_TOO_SHORT;
    end else if (snap.udp_length < uerc_pkg::UDP_HDR_LEN) begin
      status = uerc_pkg::ST_BAD_UDP_LEN;
    end else if ({1'b0, snap.plen} < need || {1'b0, snap.byte_count} < need) begin
      status = uerc_pkg::ST_TRUNCATED;
    end else if (snap.dst_ip != local_ip) begin
      status = uerc_pkg::ST_NOT_OURS;
    end else if (snap.udp_length == uerc_pkg::UDP_HDR_LEN) begin
      status = uerc_pkg::ST_EMPTY;
    end else begin
      status = uerc_pkg::ST_REPLY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (snap_ready) begin
      sum_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      sum.status    <= status;
      sum.ip_len    <= need[15:0];
      sum.ip_raw    <= {12'b0, snap.ip_sum} + {18'b0, uerc_pkg::REPLY_TTL, 8'h00}
                       + {17'b0, need} + {17'b0, local_words} + {17'b0, src_words};
      sum.udp_raw   <= {2'b0, snap.udp_sum} + {17'b0, local_words}
                       + {17'b0, src_words} + {26'b0, uerc_pkg::PROTO_UDP}
                       + {17'b0, snap.udp_length, 1'b0};
      sum.local_ip  <= local_ip;
      sum.src_ip    <= snap.src_ip;
      sum.src_port  <= snap.src_port;
      sum.dst_port  <= snap.dst_port;
      sum.data_len  <= snap.udp_length - uerc_pkg::UDP_HDR_LEN;
    end
  end

endmodule

`default_nettype wire

// ===== src/uerc_fold.sv =====
// Output stage: folds and complements the checksums and registers the reply.
// Depends on uerc_pkg, uerc_if.
`default_nettype none

module uerc_fold (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire uerc_pkg::sum_t sum,
  input  wire logic           sum_valid,
  output logic                sum_ready,
  uerc_out_if.source          rsp
);

  logic [15:0] ip_ck;
  logic [15:0] udp_ck;
  logic        ok;

  assign sum_ready = !rsp.valid || rsp.ready;
  assign ok        = (sum.status == uerc_pkg::ST_REPLY);
  assign ip_ck     = ~uerc_pkg::fold16(sum.ip_raw);
  assign udp_ck    = ~uerc_pkg::fold16(sum.udp_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (sum_ready) begin
      rsp.valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      rsp.status             <= sum.status;
      rsp.reply_ip_len       <= ok ? sum.ip_len : '0;
      rsp.reply_ip_checksum  <= ok ? ip_ck : '0;
      rsp.reply_udp_checksum <= ok ? ((udp_ck == 16'h0000) ? 16'hFFFF : udp_ck) : '0;
      rsp.reply_src_ip       <= ok ? sum.local_ip : '0;
      rsp.reply_dst_ip       <= ok ? sum.src_ip : '0;
      rsp.reply_src_port     <= ok ? sum.dst_port : '0;
      rsp.reply_dst_port     <= ok ? sum.src_port : '0;
      rsp.reply_data_len     <= ok ? sum.data_len : '0;
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != uerc_pkg::ST_REPLY)
      |-> (rsp.reply_ip_len == '0 && rsp.reply_src_ip == '0
           && rsp.reply_ip_checksum == '0 && rsp.reply_data_len == '0))
    else $error("rejected item carries reply fields");

  a_udp_ck_nonzero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == uerc_pkg::ST_REPLY) |-> rsp.reply_udp_checksum != '0)
    else $error("zero UDP checksum sent on reply");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.reply_ip_checksum)))
    else $error("stalled reply changed");

endmodule

`default_nettype wire

// ===== src/udp_echo_reply_checksum_core.sv =====
// UDP echo reply core: takes an IPv4 packet one byte per item on pkt, and for
// each packet gives one status/reply item on rsp. A byte item is taken every
// cycle while pkt.ready is high; the per-byte sums are one add into the running
// registers. The result for a packet passes through the snapshot, check and fold
// registers to rsp, and up to three finished results can wait behind a stalled
// rsp before pkt.ready drops. local_ip is written with cfg_wr_en/cfg_wr_data;
// the user must write it only while no packet is in flight, which the block does not enforce.
// Depends on uerc_pkg, uerc_if, uerc_accum, uerc_sum, uerc_fold.
`default_nettype none

module udp_echo_reply_checksum_core (
  input  wire logic        clk,
  input  wire logic        rst,
  uerc_in_if.sink          pkt,
  uerc_out_if.source       rsp,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  logic [31:0]     local_ip;
  uerc_pkg::snap_t snap;
  logic            snap_valid;
  logic            snap_ready;
  uerc_pkg::sum_t  sum;
  logic            sum_valid;
  logic            sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= '0;
    end else if (cfg_wr_en) begin
      local_ip <= cfg_wr_data;
    end
  end

  uerc_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .pkt        (pkt),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready)
  );

  uerc_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .snap       (snap),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .local_ip   (local_ip),
    .sum        (sum),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready)
  );

  uerc_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .sum       (sum),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== dv/tb_udp_echo_reply_checksum_core.sv =====
// Testbench for udp_echo_reply_checksum_core: streams IPv4/UDP packets byte by byte,
// predicts each echo reply or status in a local model and checks every result field.
// Depends on uerc_pkg, uerc_if and the core RTL.
`timescale 1ns / 100ps

module tb_udp_echo_reply_checksum_core;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int FRAME_MAX      = 65600;

  typedef struct packed {
    uerc_pkg::status_t status;
    logic [15:0] ip_len;
    logic [15:0] ip_csum;
    logic [15:0] udp_csum;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] data_len;
  } echo_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  uerc_in_if  pkt_ch ();
  uerc_out_if rsp_ch ();

  udp_echo_reply_checksum_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // packet under construction
  logic [7:0] frame [0:FRAME_MAX-1];

  // local copy of the core's per-packet state
  logic [31:0]     host_ip = '0;
  int unsigned     rx_count = 0;
  longint unsigned hdr_sum = 0;
  longint unsigned seg_sum = 0;
  logic [31:0]     peer_ip = '0;
  logic [31:0]     dest_ip = '0;
  logic [15:0]     peer_port = '0;
  logic [15:0]     dest_port = '0;
  logic [15:0]     seg_len = '0;

  echo_reply_t replies_due [$];
  echo_reply_t head;

  int  err_count = 0;
  int  n_bytes = 0;
  int  n_packets = 0;
  int  n_addr_writes = 0;
  int  status_seen [0:5];
  bit  calm = 1'b0;
  int  rsp_hold = 0;
  int  quiet = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] fold_ones(input longint unsigned s);
    while ((s >> 16) != 0)
      s = (s & 64'hFFFF) + (s >> 16);
    return s[15:0];
  endfunction

  function automatic longint unsigned addr_words(input logic [31:0] v);
    return v[31:16] + v[15:0];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input int unsigned hl);
    int unsigned pos;
    int unsigned u;
    longint unsigned w;
    pos = rx_count;
    w = (pos % 2) ? b : {b, 8'h00};
    if (pos < hl) begin
      if (pos >= 12 && pos < 16)
        peer_ip = {peer_ip[23:0], b};
      else if (pos >= 16 && pos < 20)
        dest_ip = {dest_ip[23:0], b};
      else if (pos != 2 && pos != 3 && pos != 8 && pos != 10 && pos != 11)
        hdr_sum += w;
    end else begin
      u = pos - hl;
      w = (u % 2) ? b : {b, 8'h00};
      if (u < 2) begin
        peer_port = {peer_port[7:0], b};
        seg_sum += w;
      end else if (u < 4) begin
        dest_port = {dest_port[7:0], b};
        seg_sum += w;
      end else if (u < 6) begin
        seg_len = {seg_len[7:0], b};
      end else if (u >= uerc_pkg::UDP_HDR_LEN && u < seg_len) begin
        seg_sum += w;
      end
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic [5:0] hl_field,
                                       input logic [15:0] plen, input bit lst);
    int unsigned hl;
    int unsigned need;
    echo_reply_t r;
    longint unsigned s;
    hl = (hl_field < uerc_pkg::MIN_HDR_LEN) ? uerc_pkg::MIN_HDR_LEN : hl_field;
    if (rx_count < uerc_pkg::BYTE_COUNT_MAX) begin
      absorb_byte(b, hl);
      rx_count++;
    end
    if (!lst)
      return;
    need = hl + seg_len;
    r = '0;
    if (plen < hl + uerc_pkg::UDP_HDR_LEN)
      r.status = uerc_pkg::ST_TOO_SHORT;
    else if (seg_len < uerc_pkg::UDP_HDR_LEN)
      r.status = uerc_pkg::ST_BAD_UDP_LEN;
    else if (plen < need || rx_count < need)
      r.status = uerc_pkg::ST_TRUNCATED;
    else if (dest_ip != host_ip)
      r.status = uerc_pkg::ST_NOT_OURS;
    else if (seg_len == uerc_pkg::UDP_HDR_LEN)
      r.status = uerc_pkg::ST_EMPTY;
    else
      r.status = uerc_pkg::ST_REPLY;
    if (r.status == uerc_pkg::ST_REPLY) begin
      s = hdr_sum + {uerc_pkg::REPLY_TTL, 8'h00} + need + addr_words(host_ip)
          + addr_words(peer_ip);
      r.ip_len = 16'(need);
      r.ip_csum = ~fold_ones(s);
      s = seg_sum + addr_words(host_ip) + addr_words(peer_ip) + uerc_pkg::PROTO_UDP
          + seg_len + seg_len;
      r.udp_csum = ~fold_ones(s);
      if (r.udp_csum == 16'h0000)
        r.udp_csum = 16'hFFFF;
      r.src_ip = host_ip;
      r.dst_ip = peer_ip;
      r.src_port = dest_port;
      r.dst_port = peer_port;
      r.data_len = seg_len - uerc_pkg::UDP_HDR_LEN;
    end
    replies_due.push_back(r);
    status_seen[r.status]++;
    n_packets++;
    rx_count = 0;
    hdr_sum = 0;
    seg_sum = 0;
    peer_ip = '0;
    dest_ip = '0;
    peer_port = '0;
    dest_port = '0;
    seg_len = '0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  function automatic void put16(input int p, input logic [15:0] v);
    frame[p] = v[15:8];
    frame[p+1] = v[7:0];
  endfunction

  // random bytes with the addressing fields placed; returns the byte count
  function automatic int build_frame(input int hl, input logic [31:0] src,
                                     input logic [31:0] dst, input logic [15:0] sport,
                                     input logic [15:0] dport, input logic [15:0] ulen,
                                     input int body);
    int n;
    n = hl + 8 + body;
    for (int i = 0; i < n; i++)
      frame[i] = 8'($urandom_range(0, 255));
    frame[0] = {4'd4, 4'(hl / 4)};
    frame[9] = uerc_pkg::PROTO_UDP;
    put16(12, src[31:16]);
    put16(14, src[15:0]);
    put16(16, dst[31:16]);
    put16(18, dst[15:0]);
    put16(hl, sport);
    put16(hl + 2, dport);
    put16(hl + 4, ulen);
    return n;
  endfunction

  // called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic [5:0] hl, input logic [15:0] plen,
                           input bit lst);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      pkt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pkt_ch.valid <= 1'b1;
    pkt_ch.data_byte <= b;
    pkt_ch.header_len <= hl;
    pkt_ch.packet_len <= plen;
    pkt_ch.last <= lst;
    do @(posedge clk); while (!pkt_ch.ready);
    predict_byte(b, hl, plen, lst);
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int n, input logic [5:0] hl, input logic [15:0] plen);
    for (int i = 0; i < n; i++)
      send_byte(frame[i], hl, plen, i == n - 1);
  endtask

  task automatic drain_replies();
    pkt_ch.valid <= 1'b0;
    while (replies_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_local_ip(input logic [31:0] addr);
    drain_replies();
    repeat (6) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= addr;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    host_ip = addr;
    n_addr_writes++;
  endtask

  // local address still zero from reset
  task automatic test_all_zero_packet();
    int n;
    n = build_frame(20, '0, '0, '0, '0, 16'd9, 1);
    for (int i = 0; i < n; i++)
      frame[i] = 8'h00;
    put16(24, 16'd9);
    send_frame(n, 6'd20, 16'd29);
    send_frame(n, 6'd20, 16'd0);
  endtask

  task automatic test_all_ones_packet();
    int n;
    set_local_ip(32'hFFFF_FFFF);
    n = build_frame(60, '1, '1, '1, '1, 16'd16, 8);
    for (int i = 0; i < n; i++)
      frame[i] = 8'hFF;
    put16(64, 16'd16);
    send_frame(n, 6'd60, 16'hFFFF);
  endtask

  task automatic test_status_order();
    int n;
    logic [31:0] peer;
    peer = $urandom;
    set_local_ip(32'hC0A8_0A01);
    n = build_frame(20, peer, host_ip, 16'd1234, 16'd7, 16'd12, 4);
    send_frame(n, 6'd20, 16'd27);
    n = build_frame(20, peer, host_ip, 16'd1234, 16'd7, 16'd7, 4);
    send_frame(n, 6'd20, 16'd32);
    n = build_frame(20, peer, host_ip, 16'd1234, 16'd7, 16'd20, 5);
    send_frame(n, 6'd20, 16'd40);
    n = build_frame(20, peer, host_ip, 16'd1234, 16'd7, 16'd20, 12);
    send_frame(n, 6'd20, 16'd39);
    n = build_frame(20, peer, host_ip ^ 32'h1, 16'd1234, 16'd7, 16'd12, 4);
    send_frame(n, 6'd20, 16'd32);
    n = build_frame(20, peer, host_ip, 16'd1234, 16'd7, 16'd8, 0);
    send_frame(n, 6'd20, 16'd28);
    // lone byte: UDP length never seen
    frame[0] = 8'h45;
    send_frame(1, 6'd20, 16'hFFFF);
    n = build_frame(20, peer, host_ip, 16'd1234, 16'd7, 16'd11, 3);
    send_frame(n, 6'd20, 16'd31);
  endtask

  task automatic test_header_len_cases();
    int n;
    n = build_frame(20, $urandom, host_ip, 16'($urandom), 16'($urandom), 16'd14, 6);
    send_frame(n, 6'd3, 16'd34);
    n = build_frame(21, $urandom, host_ip, 16'($urandom), 16'($urandom), 16'd13, 5);
    send_frame(n, 6'd21, 16'd34);
    n = build_frame(60, $urandom, host_ip, 16'($urandom), 16'($urandom), 16'd10, 2);
    send_frame(n, 6'd60, 16'd70);
    // header length wanders from byte to byte
    n = build_frame(24, $urandom, host_ip, 16'($urandom), 16'($urandom), 16'd12, 4);
    for (int i = 0; i < n; i++)
      send_byte(frame[i], $urandom_range(0, 1) ? 6'd24 : 6'd22, 16'd36, i == n - 1);
  endtask

  task automatic test_trailing_bytes();
    int n;
    n = build_frame(20, $urandom, host_ip, 16'($urandom), 16'($urandom), 16'd10, 9);
    send_frame(n, 6'd20, 16'd30);
  endtask

  // last payload word chosen so the segment sums to all ones
  task automatic test_zero_udp_checksum();
    int n;
    logic [31:0] peer;
    longint unsigned s;
    logic [15:0] w;
    peer = $urandom;
    n = build_frame(20, peer, host_ip, 16'($urandom), 16'($urandom), 16'd12, 4);
    s = {frame[20], frame[21]} + {frame[22], frame[23]} + {frame[28], frame[29]} +
        addr_words(host_ip) + addr_words(peer) + uerc_pkg::PROTO_UDP + 24;
    w = ~fold_ones(s);
    put16(30, w);
    send_frame(n, 6'd20, 16'd32);
  endtask

  task automatic test_overlong_packet();
    int n;
    calm = 1'b1;
    n = build_frame(20, $urandom, host_ip, 16'($urandom), 16'($urandom), 16'd30, 40);
    send_frame(n, 6'd20, 16'hFFFF);
    calm = 1'b0;
  endtask

  task automatic test_output_backpressure();
    int n;
    calm = 1'b1;
    rsp_hold = 400;
    for (int k = 0; k < 16; k++) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        frame[i] = 8'($urandom_range(0, 255));
      send_frame(n, 6'($urandom_range(0, 63)), 16'($urandom));
    end
    calm = 1'b0;
  endtask

  task automatic random_packet();
    int kind;
    int hl;
    int body;
    int extra;
    int n;
    logic [5:0]  hl_field;
    logic [15:0] ulen;
    logic [15:0] plen;
    logic [31:0] dst;
    kind = $urandom_range(0, 19);
    if ($urandom_range(0, 7) == 0)
      calm = !calm;
    hl = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) : 20;
    if ($urandom_range(0, 15) == 0)
      hl = $urandom_range(61, 63);
    hl_field = 6'(hl);
    if (hl == 20 && $urandom_range(0, 4) == 0)
      hl_field = 6'($urandom_range(0, 19));
    body = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
    if ($urandom_range(0, 39) == 0)
      body = $urandom_range(100, 400);
    ulen = 16'(8 + body);
    dst = host_ip;
    extra = 0;
    case (kind)
      0: dst = $urandom;
      1: ulen = 16'($urandom_range(0, 7));
      4: ulen = 16'($urandom);
      5: extra = $urandom_range(1, 10);
      default: ;
    endcase
    n = build_frame(hl, $urandom, dst, 16'($urandom), 16'($urandom), ulen, body + extra);
    plen = 16'(hl + 8 + body);
    case (kind)
      2: n = $urandom_range(1, n - 1);
      3: plen = 16'($urandom);
      6: begin
        n = $urandom_range(1, 40);
        hl_field = 6'($urandom_range(0, 63));
        plen = 16'($urandom);
      end
      default: ;
    endcase
    send_frame(n, hl_field, plen);
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    int start_pkts;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: set_local_ip(32'h0000_0000);
        2: set_local_ip(32'hFFFF_FFFF);
        default: set_local_ip($urandom);
      endcase
      start_bytes = n_bytes;
      start_pkts = n_packets;
      while (n_bytes - start_bytes < 70 || n_packets - start_pkts < 2)
        random_packet();
    end
  endtask

  initial begin
    pkt_ch.valid = 1'b0;
    pkt_ch.data_byte = '0;
    pkt_ch.header_len = '0;
    pkt_ch.packet_len = '0;
    pkt_ch.last = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    for (int i = 0; i < 6; i++)
      status_seen[i] = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_all_zero_packet();
    test_all_ones_packet();
    test_status_order();
    test_header_len_cases();
    test_trailing_bytes();
    test_zero_udp_checksum();
    test_overlong_packet();
    test_output_backpressure();
    test_random_traffic();
    drain_replies();
    repeat (10) @(negedge clk);
    $display("Sent %0d bytes in %0d packets over %0d local address settings",
             n_bytes, n_packets, n_addr_writes + 1);
    $display("Results: reply %0d, too short %0d, bad length %0d, truncated %0d, %s %0d, %s %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             "not ours", status_seen[4], "empty", status_seen[5]);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // result side: random stall per item, plus one long hold on request
  initial begin : rsp_drive
    int stall;
    rsp_ch.ready = 1'b0;
    while (rst)
      @(negedge clk);
    forever begin
      if (rsp_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (rsp_hold) @(negedge clk);
        rsp_hold = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 12);
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        $error("result with no packet pending: status %0d", rsp_ch.status);
        err_count++;
      end else begin
        head = replies_due.pop_front();
        check_field("status", head.status, rsp_ch.status);
        check_field("reply_ip_len", head.ip_len, rsp_ch.reply_ip_len);
        check_field("reply_ip_checksum", head.ip_csum, rsp_ch.reply_ip_checksum);
        check_field("reply_udp_checksum", head.udp_csum, rsp_ch.reply_udp_checksum);
        check_field("reply_src_ip", head.src_ip, rsp_ch.reply_src_ip);
        check_field("reply_dst_ip", head.dst_ip, rsp_ch.reply_dst_ip);
        check_field("reply_src_port", head.src_port, rsp_ch.reply_src_port);
        check_field("reply_dst_port", head.dst_port, rsp_ch.reply_dst_port);
        check_field("reply_data_len", head.data_len, rsp_ch.reply_data_len);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pkt_ch.valid && pkt_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
